FILE: sv/rhht_pkg.sv
// Package for the Robin Hood hash table: request and status codes, defaults.
// No dependencies.
package rhht_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Request kinds.
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

endpackage

FILE: sv/robin_hood_hash_table.sv
// Robin Hood hash table with backward-shift delete over a slot memory.
// Each probed slot is read (S_READ), then decided on and written back (S_EVAL);
// a delete's backward shift reads and then moves each following slot in S_SHFT.
// An ignored kind or a home slot beyond the table is answered from idle. One
// request is in work at a time; the next is taken as the result is read.
// Reset (synchronous, active low) empties the table at once via valid bits.
module robin_hood_hash_table #(
  parameter int SLOTS      = rhht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = rhht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = rhht_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [5:0]            in_home_slot,
  input  logic [63:0]           in_key,
  input  logic [31:0]           in_new_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [31:0]           out_read_value,
  output logic [63:0]           out_dropped_key,
  output logic [31:0]           out_dropped_value,
  output logic [6:0]            out_entry_count
);
  import rhht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_SHFT = 4'b1000
  } state_t;

  localparam int CW = $clog2(SLOTS + 1);

  state_t                state_r, state_nxt;
  logic [1:0]            kind_r;
  logic [AW:0]           idx_r, idx_nxt;       // one extra bit marks end of table
  logic [AW:0]           home_r;
  logic [KEY_BITS-1:0]   ck_r, ck_nxt;
  logic [VALUE_BITS-1:0] cv_r, cv_nxt;
  logic [AW-1:0]         cd_r, cd_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  shft_rd_r;

  logic                  ov_r;
  logic [1:0]            ost_r;
  logic [31:0]           ord_r;
  logic [63:0]           odk_r;
  logic [31:0]           odv_r;

  logic                  done;
  logic [1:0]            st_d;
  logic [31:0]           rd_d;
  logic [63:0]           dk_d;
  logic [31:0]           dv_d;

  logic [KEY_BITS-1:0]   m_key;
  logic [VALUE_BITS-1:0] m_val;
  logic [AW-1:0]         m_dist;
  logic                  m_valid;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_value;
  logic [AW-1:0]         wr_dist;
  logic                  wr_valid;
  logic                  accept;
  logic [AW:0]           home_ext;
  logic                  home_in;

  rhht_slot_mem #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_mem (
    .clk(clk), .rst_n(rst_n),
    .rd_addr(idx_r[AW-1:0]),
    .rd_key(m_key), .rd_value(m_val), .rd_dist(m_dist), .rd_valid(m_valid),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_value(wr_value),
    .wr_dist(wr_dist), .wr_valid(wr_valid)
  );

  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign home_ext = (AW + 1)'(in_home_slot);
  assign home_in  = ({26'd0, in_home_slot} < 32'(SLOTS));

  // Request sequencer: read one slot, then decide and write back; a delete hit then runs the backward shift.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ck_nxt    = ck_r;
    cv_nxt    = cv_r;
    cd_nxt    = cd_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    st_d      = ST_NOTFOUND;
    rd_d      = '0;
    dk_d      = '0;
    dv_d      = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_key    = ck_r;
    wr_value  = cv_r;
    wr_dist   = cd_r;
    wr_valid  = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = home_ext;
          ck_nxt  = in_key[KEY_BITS-1:0];
          cv_nxt  = VALUE_BITS'(in_new_value);
          cd_nxt  = '0;
          if (in_kind != KIND_LOOKUP && in_kind != KIND_INSERT &&
              in_kind != KIND_DELETE) begin
            done = 1'b1;
          end else if (!home_in) begin
            done = 1'b1;
            if (in_kind == KIND_INSERT) begin
              st_d = ST_FULL;
              dk_d = 64'(in_key[KEY_BITS-1:0]);
              dv_d = 32'(VALUE_BITS'(in_new_value));
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (idx_r[AW] || idx_r == (AW + 1)'(SLOTS)) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
          if (kind_r == KIND_INSERT) begin
            st_d = ST_FULL;
            dk_d = 64'(ck_r);
            dv_d = 32'(cv_r);
          end
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_READ;
        idx_nxt   = idx_r + 1'b1;
        case (kind_r)
          KIND_LOOKUP: begin
            if (!m_valid || (idx_r != home_r && m_dist == '0)) begin
              done = 1'b1;
              state_nxt = S_IDLE;
            end else if (m_key == ck_r) begin
              done = 1'b1;
              st_d = ST_DONE;
              rd_d = 32'(m_val);
              state_nxt = S_IDLE;
            end
          end
          KIND_INSERT: begin
            if (!m_valid || m_key == ck_r) begin
              wr_en = 1'b1;
              done  = 1'b1;
              st_d  = ST_DONE;
              state_nxt = S_IDLE;
              if (!m_valid) cnt_nxt = cnt_r + 1'b1;
            end else begin
              cd_nxt = cd_r + 1'b1;
              if (m_dist < cd_r) begin
                wr_en  = 1'b1;
                ck_nxt = m_key;
                cv_nxt = m_val;
                cd_nxt = m_dist + 1'b1;
              end
            end
          end
          KIND_DELETE: begin
            if (!m_valid) begin
              done = 1'b1;
              state_nxt = S_IDLE;
            end else if (m_key == ck_r) begin
              st_d = ST_DONE;
              if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
              state_nxt = S_SHFT;
            end
          end
          default: begin
            done = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SHFT: begin
        // Slot idx_r-1 is the hole. The read step of each shift step only reads
        // slot idx_r; the move step then moves that entry back or closes the shift.
        state_nxt = S_SHFT;
        wr_addr   = AW'(idx_r - 1'b1);
        st_d      = ST_DONE;
        if (!shft_rd_r) begin
          state_nxt = S_SHFT;
        end else if (idx_r == (AW + 1)'(SLOTS)) begin
          wr_en    = 1'b1;
          wr_valid = 1'b0;
          wr_dist  = '0;
          done     = 1'b1;
          state_nxt = S_IDLE;
        end else if (!m_valid || m_dist == '0) begin
          wr_en    = 1'b1;
          wr_valid = 1'b0;
          wr_dist  = '0;
          done     = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          wr_en    = 1'b1;
          wr_key   = m_key;
          wr_value = m_val;
          wr_dist  = m_dist - 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shift needs a fresh read of the slot after the hole: insert a read
  // step by tracking whether the memory output is for idx_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      ov_r      <= 1'b0;
      shft_rd_r <= 1'b0;
    end else begin
      if (state_r == S_SHFT && !shft_rd_r) begin
        // Read step for the slot now addressed; hold everything else.
        shft_rd_r <= 1'b1;
      end else begin
        state_r   <= state_nxt;
        cnt_r     <= cnt_nxt;
        shft_rd_r <= 1'b0;
        if (done) ov_r <= 1'b1;
        else if (out_ready) ov_r <= 1'b0;
      end
      if (state_r == S_SHFT && !shft_rd_r && out_ready) ov_r <= 1'b0;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    if (!(state_r == S_SHFT && !shft_rd_r)) begin
      idx_r <= (state_r == S_EVAL && state_nxt == S_SHFT) ? idx_r + 1'b1 : idx_nxt;
      ck_r  <= ck_nxt;
      cv_r  <= cv_nxt;
      cd_r  <= cd_nxt;
      if (done) begin
        ost_r <= st_d;
        ord_r <= rd_d;
        odk_r <= dk_d;
        odv_r <= dv_d;
      end
    end
    if (accept) begin
      kind_r <= in_kind;
      home_r <= home_ext;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_read_value    = ord_r;
  assign out_dropped_key   = odk_r;
  assign out_dropped_value = odv_r;
  assign out_entry_count   = 7'(cnt_r);

endmodule

FILE: sv/rhht_slot_mem.sv
// Slot memory of the hash table: one synchronous write port and one registered read port.
// Valid bits live in flip-flops so reset clears them at once.
// Depends on rhht_pkg.
module rhht_slot_mem #(
  parameter int SLOTS      = rhht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = rhht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = rhht_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [AW-1:0]         rd_addr,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [VALUE_BITS-1:0] rd_value,
  output logic [AW-1:0]         rd_dist,
  output logic                  rd_valid,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  logic [AW-1:0]         wr_dist,
  input  logic                  wr_valid
);
  import rhht_pkg::*;

  logic [KEY_BITS-1:0]   key_mem   [SLOTS];
  logic [VALUE_BITS-1:0] value_mem [SLOTS];
  logic [AW-1:0]         dist_mem  [SLOTS];
  logic [SLOTS-1:0]      valid_r;

  // Payload arrays: write then registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
      dist_mem[wr_addr]  <= wr_dist;
    end
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
    rd_dist  <= dist_mem[rd_addr];
  end

  // Valid bits; reset marks every slot empty at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= wr_valid;
      rd_valid <= valid_r[rd_addr];
    end
  end

endmodule

FILE: tb/sv/tb_robin_hood_hash_table.sv
// Testbench for the Robin Hood hash table: directed and random requests
// checked against a slot-level predictor held in a scoreboard class.
// Depends on rhht_pkg and robin_hood_hash_table.
`timescale 1ns / 1ps

module tb_robin_hood_hash_table;
  import rhht_pkg::*;

  localparam int NSLOT = 64;

  // One expected result.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [63:0] dropped_key;
    logic [31:0] dropped_value;
    logic [6:0]  entry_count;
  } reply_t;

  int error_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Scoreboard: holds a shadow copy of the table and the pending replies.
  class table_scoreboard;
    logic [63:0] shadow_key[NSLOT];
    logic [31:0] shadow_value[NSLOT];
    bit          shadow_valid[NSLOT];
    int          shadow_dist[NSLOT];
    int          occupied;
    reply_t      pending_replies[$];
    int          checked;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        shadow_valid[i] = 0;
        shadow_dist[i] = 0;
        shadow_key[i] = '0;
        shadow_value[i] = '0;
      end
      occupied = 0;
      checked = 0;
    endfunction

    function void clear_entry(int i);
      shadow_valid[i] = 0;
      shadow_dist[i] = 0;
    endfunction

    // Apply one request to the shadow table and queue its reply.
    function void note_request(logic [1:0] kind, int home, logic [63:0] key,
                               logic [31:0] val);
      reply_t r;
      logic [63:0] ck, tk;
      logic [31:0] cv, tv;
      int cd, td, i, j;
      bit placed;
      r = '0;
      r.status = ST_NOTFOUND;
      if (kind == KIND_LOOKUP) begin
        for (i = home; i < NSLOT; i++) begin
          if (!shadow_valid[i] || (i != home && shadow_dist[i] == 0)) break;
          if (shadow_key[i] == key) begin
            r.status = ST_DONE;
            r.read_value = shadow_value[i];
            break;
          end
        end
      end else if (kind == KIND_INSERT) begin
        ck = key; cv = val; cd = 0; placed = 0;
        for (i = home; i < NSLOT; i++) begin
          if (!shadow_valid[i]) begin
            occupied++;
            placed = 1;
            break;
          end
          if (shadow_key[i] == ck) begin
            placed = 1;
            break;
          end
          if (shadow_dist[i] < cd) begin
            tk = shadow_key[i]; tv = shadow_value[i]; td = shadow_dist[i];
            shadow_key[i] = ck; shadow_value[i] = cv; shadow_dist[i] = cd;
            ck = tk; cv = tv; cd = td;
          end
          cd++;
        end
        if (placed) begin
          shadow_key[i] = ck;
          shadow_value[i] = cv;
          shadow_dist[i] = cd;
          shadow_valid[i] = 1;
          r.status = ST_DONE;
        end else begin
          r.status = ST_FULL;
          r.dropped_key = ck;
          r.dropped_value = cv;
        end
      end else if (kind == KIND_DELETE) begin
        for (i = home; i < NSLOT; i++) begin
          if (!shadow_valid[i]) break;
          if (shadow_key[i] == key) begin
            r.status = ST_DONE;
            if (occupied > 0) occupied--;
            for (j = i + 1; j < NSLOT; j++) begin
              clear_entry(j - 1);
              if (!shadow_valid[j] || shadow_dist[j] == 0) break;
              shadow_key[j - 1] = shadow_key[j];
              shadow_value[j - 1] = shadow_value[j];
              shadow_dist[j - 1] = shadow_dist[j] - 1;
              shadow_valid[j - 1] = 1;
            end
            if (j >= NSLOT) clear_entry(NSLOT - 1);
            break;
          end
        end
      end
      r.entry_count = occupied[6:0];
      pending_replies.push_back(r);
    endfunction

    // Compare one observed reply with the oldest pending one.
    task check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(got.status), 64'd0);
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", 64'(got.read_value), 64'(want.read_value));
      if (got.dropped_key !== want.dropped_key)
        report_mismatch("dropped_key", got.dropped_key, want.dropped_key);
      if (got.dropped_value !== want.dropped_value)
        report_mismatch("dropped_value", 64'(got.dropped_value),
                        64'(want.dropped_value));
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [5:0]  in_home_slot = '0;
  logic [63:0] in_key = '0;
  logic [31:0] in_new_value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [63:0] out_dropped_key;
  logic [31:0] out_dropped_value;
  logic [6:0]  out_entry_count;

  robin_hood_hash_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_home_slot(in_home_slot),
    .in_key(in_key), .in_new_value(in_new_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_read_value(out_read_value),
    .out_dropped_key(out_dropped_key), .out_dropped_value(out_dropped_value),
    .out_entry_count(out_entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  table_scoreboard board = new();
  int send_idle_pct = 9;
  int recv_idle_pct = 83;
  longint cycle_count = 0;
  int kinds_sent[4] = '{0, 0, 0, 0};

  // Key pool so that lookups and deletes often hit stored keys.
  logic [63:0] key_pool[16];

  // Cycle limit: ends the run as failed if the requests, with their stalls, take too long.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("robin_hood_hash_table test failed");
      $finish;
    end
  end

  // Result side: random stalls, check on each transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_reply({out_status, out_read_value, out_dropped_key,
                           out_dropped_value, out_entry_count});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one request and wait for its transfer. Valid stays high into the
  // next request unless the sender idles first.
  task automatic send_request(input logic [1:0] kind, input logic [5:0] home,
                              input logic [63:0] key, input logic [31:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_home_slot <= home;
    in_key <= key;
    in_new_value <= val;
    do @(posedge clk); while (!in_ready);
    board.note_request(kind, int'(home), key, val);
    kinds_sent[kind]++;
  endtask

  // Random requests biased toward high home slots to reach the table end.
  task automatic send_random(input int count, input int key_span);
    logic [1:0] kind;
    logic [5:0] home;
    logic [63:0] key;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      kind = (pick < 45) ? KIND_INSERT : (pick < 70) ? KIND_LOOKUP :
             (pick < 95) ? KIND_DELETE : 2'd3;
      key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                     : key_pool[$urandom_range(key_span - 1)];
      home = ($urandom_range(3) == 0) ? 6'($urandom_range(48, 63)) : key[5:0];
      send_request(kind, home, key, $urandom);
    end
  endtask

  initial begin
    for (int k = 0; k < 16; k++) key_pool[k] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty table, extremes, replace, collisions, end of table.
    send_request(KIND_LOOKUP, 6'd0, 64'd0, 32'd0);
    send_request(KIND_DELETE, 6'd63, '1, '1);
    send_request(KIND_INSERT, 6'd0, 64'd0, 32'd0);
    send_request(KIND_INSERT, 6'd0, '1, '1);
    send_request(KIND_INSERT, 6'd0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_request(KIND_INSERT, 6'd1, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send_request(KIND_INSERT, 6'd0, '1, 32'h1234_5678);
    send_request(KIND_LOOKUP, 6'd0, '1, 32'd0);
    send_request(KIND_LOOKUP, 6'd1, 64'h5555_5555_5555_5555, 32'd0);
    send_request(KIND_DELETE, 6'd0, 64'd0, 32'd0);
    send_request(KIND_LOOKUP, 6'd0, 64'h5555_5555_5555_5555, 32'd0);
    send_request(2'd3, 6'd7, 64'd7, 32'd7);
    send_request(KIND_INSERT, 6'd63, 64'h63, 32'h63);
    send_request(KIND_INSERT, 6'd63, 64'h64, 32'h64);
    send_request(KIND_INSERT, 6'd62, 64'h65, 32'h65);
    send_request(KIND_INSERT, 6'd62, 64'h66, 32'h66);
    send_request(KIND_DELETE, 6'd62, 64'h65, 32'd0);
    send_request(KIND_LOOKUP, 6'd63, 64'h63, 32'd0);
    send_request(KIND_DELETE, 6'd63, 64'h63, 32'd0);

    // Random phases with the idle pattern changing between them.
    send_random(150, 16);
    send_idle_pct = 83;
    recv_idle_pct = 9;
    send_random(150, 16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Fill phase: many distinct keys so the table loads up and overflows.
    for (int n = 0; n < 100; n++)
      send_request(KIND_INSERT, 6'($urandom_range(32, 63)), {$urandom, $urandom},
                   $urandom);
    send_random(50, 16);
    in_valid <= 0;

    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Checked %0d results: %0d lookups, %0d inserts, %0d deletes, %0d other.",
             board.checked, kinds_sent[0], kinds_sent[1], kinds_sent[2],
             kinds_sent[3]);
    if (error_count == 0 && board.pending_replies.size() == 0) begin
      $display("robin_hood_hash_table test passed");
    end else begin
      $display("robin_hood_hash_table test failed");
    end
    $finish;
  end

endmodule
